@@ rtl/near_pair_list_builder_core_assert.svh @@
// assertion macros for the near pair list builder
`ifndef NEAR_PAIR_LIST_BUILDER_CORE_ASSERT_SVH
`define NEAR_PAIR_LIST_BUILDER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define NPLB_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define NPLB_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define NPLB_ASSERT(label, clk, rst, prop)
`define NPLB_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ rtl/nplb_pkg.sv @@
package nplb_pkg;

   localparam int IDX_W      = 6;
   localparam int COUNT_W    = 7;
   localparam int MASK_W     = 16;
   localparam int MASK_SEL_W = $clog2(MASK_W);
   localparam int RADIUS_W   = 16;
   localparam int GROUP_W    = 2;
   localparam int GROUP_COUNT = 4;
   localparam int NEAR_FACTOR = 3;
   localparam int LIM_W      = 19;
   localparam int SQ_W       = 2 * LIM_W;
   localparam int ACC_W      = SQ_W + 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_SCAN = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_BODY_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GROUP_MASK = 1'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MASTER,
      ST_NEXT,
      ST_SLAVE,
      ST_CHECK,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQ_Z,
      ST_CMP,
      ST_PAIR,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      OP_IDLE,
      OP_MASTER,
      OP_DIFF,
      OP_SQ_LIM,
      OP_SQ_X,
      OP_SQ_Y,
      OP_SQ_Z
   } dist_op_type;

   typedef struct packed {
      dist_op_type op;
   } dist_ctl_type;

   typedef struct packed {
      logic reject;
      logic near;
   } dist_stat_type;

endpackage

@@ rtl/nplb_store.sv @@
module nplb_store import nplb_pkg::*; #(
   parameter int MAX_BODIES = 64,
   parameter int COORD_BITS = 24
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(MAX_BODIES)-1:0] wr_addr,
   input  logic [COORD_BITS-1:0]         wr_x,
   input  logic [COORD_BITS-1:0]         wr_y,
   input  logic [COORD_BITS-1:0]         wr_z,
   input  logic [RADIUS_W-1:0]           wr_radius,
   input  logic [GROUP_W-1:0]            wr_group,
   input  logic [$clog2(MAX_BODIES)-1:0] rd_addr,
   output logic [COORD_BITS-1:0]         rd_x,
   output logic [COORD_BITS-1:0]         rd_y,
   output logic [COORD_BITS-1:0]         rd_z,
   output logic [RADIUS_W-1:0]           rd_radius,
   output logic [GROUP_W-1:0]            rd_group
);

   localparam int ENTRY_W = 3 * COORD_BITS + RADIUS_W + GROUP_W;

   logic [ENTRY_W-1:0] mem [MAX_BODIES];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_x, wr_y, wr_z, wr_radius, wr_group};
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign {rd_x, rd_y, rd_z, rd_radius, rd_group} = rd_data_ff;

endmodule

@@ rtl/nplb_dist.sv @@
module nplb_dist import nplb_pkg::*; #(
   parameter int COORD_BITS = 24
) (
   input  logic                  clock,
   input  dist_ctl_type          ctl,
   input  logic [MASK_W-1:0]     group_mask,
   input  logic [COORD_BITS-1:0] rd_x,
   input  logic [COORD_BITS-1:0] rd_y,
   input  logic [COORD_BITS-1:0] rd_z,
   input  logic [RADIUS_W-1:0]   rd_radius,
   input  logic [GROUP_W-1:0]    rd_group,
   output dist_stat_type         stat
);

   localparam int DW = COORD_BITS + 1;
   localparam int CW = (COORD_BITS > LIM_W) ? COORD_BITS : LIM_W;

   function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                       input logic [COORD_BITS-1:0] b);
      logic signed [DW-1:0] d;
      d = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
      if (d[DW-1]) begin
         d = -d;
      end
      return d[COORD_BITS-1:0];
   endfunction

   logic [COORD_BITS-1:0] mx_ff, my_ff, mz_ff;
   logic [RADIUS_W-1:0]   mr_ff;
   logic [GROUP_W-1:0]    mg_ff;
   logic [COORD_BITS-1:0] dx_ff, dy_ff, dz_ff;
   logic [COORD_BITS-1:0] dx_in, dy_in, dz_in;
   logic [LIM_W-1:0]      lim_ff, lim_in;
   logic                  reject_ff, reject_in;
   logic [SQ_W-1:0]       lim_sq_ff;
   logic [ACC_W-1:0]      acc_ff;
   logic [RADIUS_W:0]     rsum;
   int unsigned           gbit;
   logic                  grp_ok;
   logic [LIM_W-1:0]      mul_a;
   logic [SQ_W-1:0]       prod;

   always_comb begin
      dx_in  = abs_diff(mx_ff, rd_x);
      dy_in  = abs_diff(my_ff, rd_y);
      dz_in  = abs_diff(mz_ff, rd_z);
      rsum   = {1'b0, mr_ff} + {1'b0, rd_radius};
      lim_in = LIM_W'(32'(rsum) * NEAR_FACTOR);
      gbit   = 32'(mg_ff) * GROUP_COUNT + 32'(rd_group);
      grp_ok = (gbit < MASK_W) && group_mask[gbit[MASK_SEL_W-1:0]];
      reject_in = !grp_ok
         || (CW'(dx_in) > CW'(lim_in))
         || (CW'(dy_in) > CW'(lim_in))
         || (CW'(dz_in) > CW'(lim_in));
   end

   always_comb begin
      case (ctl.op)
         OP_SQ_X: mul_a = LIM_W'(dx_ff);
         OP_SQ_Y: mul_a = LIM_W'(dy_ff);
         OP_SQ_Z: mul_a = LIM_W'(dz_ff);
         default: mul_a = lim_ff;
      endcase
      prod = SQ_W'(mul_a) * SQ_W'(mul_a);
   end

   always_ff @(posedge clock) begin
      case (ctl.op)
         OP_MASTER: begin
            mx_ff <= rd_x;
            my_ff <= rd_y;
            mz_ff <= rd_z;
            mr_ff <= rd_radius;
            mg_ff <= rd_group;
         end
         OP_DIFF: begin
            dx_ff     <= dx_in;
            dy_ff     <= dy_in;
            dz_ff     <= dz_in;
            lim_ff    <= lim_in;
            reject_ff <= reject_in;
         end
         OP_SQ_LIM: lim_sq_ff <= prod;
         OP_SQ_X:   acc_ff <= ACC_W'(prod);
         OP_SQ_Y:   acc_ff <= acc_ff + ACC_W'(prod);
         OP_SQ_Z:   acc_ff <= acc_ff + ACC_W'(prod);
         default: begin
         end
      endcase
   end

   assign stat.reject = reject_ff;
   assign stat.near   = acc_ff <= ACC_W'(lim_sq_ff);

endmodule

@@ rtl/nplb_ctrl.sv @@
`include "near_pair_list_builder_core_assert.svh"

module nplb_ctrl import nplb_pkg::*; #(
   parameter int MAX_BODIES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_kind,
   input  logic [IDX_W-1:0]              req_body_index,
   input  logic [COUNT_W-1:0]            count,
   output logic                          wr_en,
   output logic [$clog2(MAX_BODIES)-1:0] wr_addr,
   output logic [$clog2(MAX_BODIES)-1:0] rd_addr,
   output dist_ctl_type                  ctl,
   input  dist_stat_type                 stat,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [IDX_W-1:0]              rsp_master_index,
   output logic [IDX_W-1:0]              rsp_slave_index,
   output logic                          rsp_pair_valid,
   output logic                          rsp_last
);

   localparam int AW = $clog2(MAX_BODIES);

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [COUNT_W-1:0] j_ff, j_in;
   logic               has_pend_ff, has_pend_in;
   logic [IDX_W-1:0]   pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]   rsp_master_ff, rsp_slave_ff, emit_slave;
   logic               rsp_pair_ff, rsp_last_ff, emit_pair, emit_last;
   logic               emit, out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign wr_en    = req_valid && req_ready && (req_kind == KIND_LOAD)
                     && (32'(req_body_index) < MAX_BODIES);
   assign wr_addr  = AW'(req_body_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         has_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         has_pend_ff  <= has_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      j_ff    <= j_in;
      pend_ff <= pend_in;
      if (emit) begin
         rsp_master_ff <= idx_ff;
         rsp_slave_ff  <= emit_slave;
         rsp_pair_ff   <= emit_pair;
         rsp_last_ff   <= emit_last;
      end
   end

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      j_in        = j_ff;
      has_pend_in = has_pend_ff;
      pend_in     = pend_ff;
      req_ready   = 1'b0;
      rd_addr     = AW'(j_ff);
      ctl.op      = OP_IDLE;
      emit        = 1'b0;
      emit_slave  = pend_ff;
      emit_pair   = 1'b1;
      emit_last   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            rd_addr   = AW'(req_body_index);
            if (req_valid && (req_kind == KIND_SCAN)) begin
               idx_in   = req_body_index;
               j_in     = COUNT_W'(req_body_index) + COUNT_W'(1);
               state_in = ST_MASTER;
            end
         end
         ST_MASTER: begin
            ctl.op   = OP_MASTER;
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            if (j_ff < count) begin
               state_in = ST_SLAVE;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SLAVE: begin
            ctl.op   = OP_DIFF;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (stat.reject) begin
               j_in     = j_ff + COUNT_W'(1);
               state_in = ST_NEXT;
            end else begin
               ctl.op   = OP_SQ_LIM;
               state_in = ST_SQ_X;
            end
         end
         ST_SQ_X: begin
            ctl.op   = OP_SQ_X;
            state_in = ST_SQ_Y;
         end
         ST_SQ_Y: begin
            ctl.op   = OP_SQ_Y;
            state_in = ST_SQ_Z;
         end
         ST_SQ_Z: begin
            ctl.op   = OP_SQ_Z;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (stat.near) begin
               state_in = ST_PAIR;
            end else begin
               j_in     = j_ff + COUNT_W'(1);
               state_in = ST_NEXT;
            end
         end
         ST_PAIR: begin
            // hold one pair back so the final one can carry last
            if (!has_pend_ff) begin
               has_pend_in = 1'b1;
               pend_in     = j_ff[IDX_W-1:0];
               j_in        = j_ff + COUNT_W'(1);
               state_in    = ST_NEXT;
            end else if (out_free) begin
               emit     = 1'b1;
               pend_in  = j_ff[IDX_W-1:0];
               j_in     = j_ff + COUNT_W'(1);
               state_in = ST_NEXT;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               emit        = 1'b1;
               emit_slave  = has_pend_ff ? pend_ff : '0;
               emit_pair   = has_pend_ff;
               emit_last   = 1'b1;
               has_pend_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_master_index = rsp_master_ff;
   assign rsp_slave_index  = rsp_slave_ff;
   assign rsp_pair_valid   = rsp_pair_ff;
   assign rsp_last         = rsp_last_ff;

   `NPLB_ASSERT(a_pair_order, clock, reset, rsp_valid_ff && rsp_pair_ff |-> rsp_slave_ff > rsp_master_ff)
   `NPLB_ASSERT(a_marker_last, clock, reset, rsp_valid_ff && !rsp_pair_ff |-> rsp_last_ff)
   `NPLB_ASSERT(a_slave_above, clock, reset, state_ff == ST_NEXT |-> j_ff > COUNT_W'(idx_ff))
   `NPLB_ASSERT(a_pend_clear, clock, reset, state_ff == ST_FINISH && state_in == ST_IDLE |=> !has_pend_ff)

endmodule

@@ rtl/near_pair_list_builder_core.sv @@
// near pair list builder
// req channel: kind 0 writes one body (position, radius, group) at body_index;
//   kind 1 scans master index body_index against every higher index below
//   body_count.
// rsp channel: one transaction per near pair in ascending slave order, the final
//   one flagged last; a scan with no pair gives one marker with pair_valid low.
// csr channel: index 0 body_count, index 1 group_pair_mask; always ready.
// a scan fetches the master, then reads the slaves one at a time; a slave is
//   rejected by group or by the per-axis bound, else it reaches the squared
//   distance test on the shared multiplier, plus a pair step when it is a pair;
//   a finish step sends the last result; req_ready is low for the whole scan.
// the store is one memory port read per cycle, so slaves are visited one by one.
// reset clears state and both registers; the body store is not cleared and
//   must be loaded before a scan reads it.
// a stalled receiver holds the current result; the scan keeps running with one
//   pair held back and waits only when a second result is ready to go out.
module near_pair_list_builder_core import nplb_pkg::*; #(
   parameter int MAX_BODIES = 64,
   parameter int COORD_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_kind,
   input  logic [IDX_W-1:0]      req_body_index,
   input  logic [COORD_BITS-1:0] req_pos_x,
   input  logic [COORD_BITS-1:0] req_pos_y,
   input  logic [COORD_BITS-1:0] req_pos_z,
   input  logic [RADIUS_W-1:0]   req_radius,
   input  logic [GROUP_W-1:0]    req_group,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [IDX_W-1:0]      rsp_master_index,
   output logic [IDX_W-1:0]      rsp_slave_index,
   output logic                  rsp_pair_valid,
   output logic                  rsp_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = $clog2(MAX_BODIES);

   logic [COUNT_W-1:0]    body_count_ff;
   logic [MASK_W-1:0]     group_mask_ff;
   logic [COUNT_W-1:0]    count_sat;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [COORD_BITS-1:0] rd_x, rd_y, rd_z;
   logic [RADIUS_W-1:0]   rd_radius;
   logic [GROUP_W-1:0]    rd_group;
   dist_ctl_type          ctl;
   dist_stat_type         stat;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         body_count_ff <= '0;
         group_mask_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_BODY_COUNT: body_count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_GROUP_MASK: group_mask_ff <= csr_wdata[MASK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign count_sat = (32'(body_count_ff) > MAX_BODIES) ? COUNT_W'(MAX_BODIES) : body_count_ff;

   nplb_store #(
      .MAX_BODIES(MAX_BODIES),
      .COORD_BITS(COORD_BITS)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_x      (req_pos_x),
      .wr_y      (req_pos_y),
      .wr_z      (req_pos_z),
      .wr_radius (req_radius),
      .wr_group  (req_group),
      .rd_addr   (rd_addr),
      .rd_x      (rd_x),
      .rd_y      (rd_y),
      .rd_z      (rd_z),
      .rd_radius (rd_radius),
      .rd_group  (rd_group)
   );

   nplb_dist #(
      .COORD_BITS(COORD_BITS)
   ) u_dist (
      .clock      (clock),
      .ctl        (ctl),
      .group_mask (group_mask_ff),
      .rd_x       (rd_x),
      .rd_y       (rd_y),
      .rd_z       (rd_z),
      .rd_radius  (rd_radius),
      .rd_group   (rd_group),
      .stat       (stat)
   );

   nplb_ctrl #(
      .MAX_BODIES(MAX_BODIES)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_body_index   (req_body_index),
      .count            (count_sat),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .rd_addr          (rd_addr),
      .ctl              (ctl),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_master_index (rsp_master_index),
      .rsp_slave_index  (rsp_slave_index),
      .rsp_pair_valid   (rsp_pair_valid),
      .rsp_last         (rsp_last)
   );

endmodule

@@ tb/tb.sv @@
module tb;
   import nplb_pkg::*;

   localparam int MAX_BODIES = 64;
   localparam int COORD_W    = 24;
   localparam int SETTLE     = 16;
   localparam int MAXC       = 8388607;
   localparam int MINC       = -8388608;

   typedef struct packed {
      logic [IDX_W-1:0] master;
      logic [IDX_W-1:0] slave;
      logic             pair_valid;
      logic             last;
   } pair_rec_type;

   class near_pair_board_type;
      logic signed [COORD_W-1:0] x_mem [MAX_BODIES];
      logic signed [COORD_W-1:0] y_mem [MAX_BODIES];
      logic signed [COORD_W-1:0] z_mem [MAX_BODIES];
      logic [RADIUS_W-1:0]       r_mem [MAX_BODIES];
      logic [GROUP_W-1:0]        g_mem [MAX_BODIES];
      logic [COUNT_W-1:0]        body_count;
      logic [MASK_W-1:0]         group_mask;
      pair_rec_type              pending [$];
      int                        mismatches;

      function new();
         body_count = '0;
         group_mask = '0;
         mismatches = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_BODY_COUNT)
            body_count = data[COUNT_W-1:0];
         else if (idx == CSR_GROUP_MASK)
            group_mask = data[MASK_W-1:0];
      endfunction

      function void note_request(logic kind, logic [IDX_W-1:0] idx,
                                 logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                 logic [COORD_W-1:0] z, logic [RADIUS_W-1:0] r,
                                 logic [GROUP_W-1:0] g);
         int span, sel;
         longint lim, dx, dy, dz;
         pair_rec_type held;
         bit have_held;
         if (kind == KIND_LOAD) begin
            x_mem[idx] = x;
            y_mem[idx] = y;
            z_mem[idx] = z;
            r_mem[idx] = r;
            g_mem[idx] = g;
            return;
         end
         span = (body_count > MAX_BODIES) ? MAX_BODIES : int'(body_count);
         have_held = 1'b0;
         held = '0;
         for (int j = int'(idx) + 1; j < span; j++) begin
            sel = int'(g_mem[idx]) * GROUP_COUNT + int'(g_mem[j]);
            if (sel >= MASK_W || !group_mask[sel])
               continue;
            lim = (longint'(r_mem[idx]) + longint'(r_mem[j])) * NEAR_FACTOR;
            dx = longint'(x_mem[idx]) - longint'(x_mem[j]);
            dy = longint'(y_mem[idx]) - longint'(y_mem[j]);
            dz = longint'(z_mem[idx]) - longint'(z_mem[j]);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            if (dz < 0) dz = -dz;
            if (dx > lim || dy > lim || dz > lim)
               continue;
            if (dx * dx + dy * dy + dz * dz > lim * lim)
               continue;
            if (have_held)
               pending.insert(pending.size(), held);
            held.master = idx;
            held.slave = IDX_W'(j);
            held.pair_valid = 1'b1;
            held.last = 1'b0;
            have_held = 1'b1;
         end
         if (!have_held) begin
            held.master = idx;
            held.slave = '0;
            held.pair_valid = 1'b0;
         end
         held.last = 1'b1;
         pending.insert(pending.size(), held);
      endfunction

      function void check_result(logic [IDX_W-1:0] m, logic [IDX_W-1:0] s,
                                 logic pv, logic l);
         pair_rec_type want;
         if (pending.size() == 0) begin
            $display("%0t unexpected result: expected none, actual m=%0d s=%0d v=%0b l=%0b",
                     $time, m, s, pv, l);
            mismatches++;
            return;
         end
         want = pending.pop_front();
         if (want.master !== m || want.slave !== s || want.pair_valid !== pv ||
             want.last !== l) begin
            $display("%0t mismatch: expected m=%0d s=%0d v=%0b l=%0b, actual m=%0d s=%0d v=%0b l=%0b",
                     $time, want.master, want.slave, want.pair_valid, want.last,
                     m, s, pv, l);
            mismatches++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_kind = KIND_LOAD;
   logic [IDX_W-1:0]      req_body_index = '0;
   logic [COORD_W-1:0]    req_pos_x = '0;
   logic [COORD_W-1:0]    req_pos_y = '0;
   logic [COORD_W-1:0]    req_pos_z = '0;
   logic [RADIUS_W-1:0]   req_radius = '0;
   logic [GROUP_W-1:0]    req_group = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [IDX_W-1:0]      rsp_master_index;
   logic [IDX_W-1:0]      rsp_slave_index;
   logic                  rsp_pair_valid;
   logic                  rsp_last;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   near_pair_board_type board = new();
   bit calm = 1'b0;

   near_pair_list_builder_core #(
      .MAX_BODIES(MAX_BODIES),
      .COORD_BITS(COORD_W)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_body_index(req_body_index),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .req_pos_z(req_pos_z),
      .req_radius(req_radius),
      .req_group(req_group),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_master_index(rsp_master_index),
      .rsp_slave_index(rsp_slave_index),
      .rsp_pair_valid(rsp_pair_valid),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic int pick_gap();
      int roll;
      if (calm)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 50)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic logic [COORD_W-1:0] rand_coord();
      return COORD_W'($urandom);
   endfunction

   function automatic logic [COORD_W-1:0] near_coord(int center);
      return COORD_W'(center + int'($urandom_range(0, 400)));
   endfunction

   function automatic logic [RADIUS_W-1:0] cluster_radius();
      if ($urandom_range(0, 9) < 8)
         return RADIUS_W'($urandom_range(0, 150));
      return RADIUS_W'($urandom);
   endfunction

   function automatic logic [IDX_W-1:0] pick_slot(int span);
      if (span > 0 && $urandom_range(0, 9) < 9)
         return IDX_W'($urandom_range(0, span - 1));
      return IDX_W'($urandom_range(0, MAX_BODIES - 1));
   endfunction

   task automatic send_req(input logic kind, input logic [IDX_W-1:0] idx,
                           input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                           input logic [COORD_W-1:0] z, input logic [RADIUS_W-1:0] r,
                           input logic [GROUP_W-1:0] g);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_body_index <= idx;
      req_pos_x <= x;
      req_pos_y <= y;
      req_pos_z <= z;
      req_radius <= r;
      req_group <= g;
      do @(negedge clock); while (!req_ready);
      board.note_request(kind, idx, x, y, z, r, g);
      @(posedge clock);
   endtask

   task automatic scan_master(input logic [IDX_W-1:0] idx);
      send_req(KIND_SCAN, idx, rand_coord(), rand_coord(), rand_coord(),
               RADIUS_W'($urandom), GROUP_W'($urandom));
   endtask

   // waits for the block to drain before touching a register
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(negedge clock); while (!csr_ready);
      board.set_register(idx, data);
      @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_result(rsp_master_index, rsp_slave_index, rsp_pair_valid, rsp_last);
   end

   initial begin : rsp_pacing
      int busy, stall;
      @(posedge clock);
      forever begin
         busy = calm ? 200 : $urandom_range(1, 12);
         rsp_ready <= 1'b1;
         repeat (busy) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   initial begin
      #20000000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      int ph, made, burst, span, roll, cx, cy, cz;
      logic [CSR_DATA_W-1:0] count_word, mask_word;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // every entry written once so no scan reads an empty slot
      for (int i = 0; i < MAX_BODIES; i++)
         send_req(KIND_LOAD, IDX_W'(i), rand_coord(), rand_coord(), rand_coord(),
                  RADIUS_W'($urandom), GROUP_W'($urandom));

      write_csr(CSR_BODY_COUNT, 16'd8);
      write_csr(CSR_GROUP_MASK, 16'hFFFF);
      send_req(KIND_LOAD, 6'd0, '0, '0, '0, '0, 2'd0);
      send_req(KIND_LOAD, 6'd1, '0, '0, '0, '0, 2'd3);
      send_req(KIND_LOAD, 6'd2, COORD_W'(MAXC), COORD_W'(MAXC), COORD_W'(MAXC),
               16'hFFFF, 2'd2);
      send_req(KIND_LOAD, 6'd3, COORD_W'(MAXC - 393210), COORD_W'(MAXC), COORD_W'(MAXC),
               16'hFFFF, 2'd1);
      send_req(KIND_LOAD, 6'd4, COORD_W'(MAXC - 393211), COORD_W'(MAXC), COORD_W'(MAXC),
               16'hFFFF, 2'd2);
      send_req(KIND_LOAD, 6'd5, COORD_W'(MINC), COORD_W'(MINC), COORD_W'(MINC),
               16'hFFFF, 2'd3);
      send_req(KIND_LOAD, 6'd6, COORD_W'(MINC + 227000), COORD_W'(MINC + 227000),
               COORD_W'(MINC + 227000), 16'hFFFF, 2'd0);
      send_req(KIND_LOAD, 6'd7, COORD_W'(MINC + 227100), COORD_W'(MINC + 227100),
               COORD_W'(MINC + 227100), 16'hFFFF, 2'd1);
      for (int i = 0; i < 8; i++)
         scan_master(IDX_W'(i));
      scan_master(6'd63);
      write_csr(CSR_GROUP_MASK, 16'h0008);
      scan_master(6'd0);
      scan_master(6'd2);
      write_csr(CSR_GROUP_MASK, 16'h0000);
      scan_master(6'd0);
      write_csr(CSR_GROUP_MASK, 16'hFFFF);
      write_csr(CSR_BODY_COUNT, 16'hFF7F);
      scan_master(6'd60);
      write_csr(CSR_BODY_COUNT, 16'd0);
      scan_master(6'd0);

      for (ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               count_word = 16'd64;
               mask_word = 16'hFFFF;
            end
            1: begin
               count_word = 16'($urandom) | 16'h007F;
               mask_word = 16'($urandom);
            end
            2: begin
               count_word = 16'($urandom_range(2, 64));
               mask_word = 16'hFFFF;
            end
            3: begin
               count_word = 16'd1;
               mask_word = 16'($urandom);
            end
            4: begin
               count_word = 16'd64;
               mask_word = 16'($urandom) | 16'h8421;
            end
            default: begin
               count_word = 16'($urandom);
               mask_word = 16'($urandom);
            end
         endcase
         write_csr(CSR_BODY_COUNT, count_word);
         write_csr(CSR_GROUP_MASK, mask_word);
         calm = (ph == 2);
         span = (count_word[COUNT_W-1:0] > MAX_BODIES) ? MAX_BODIES
                                                       : int'(count_word[COUNT_W-1:0]);
         cx = int'($urandom_range(0, 16000000)) - 8000000;
         cy = int'($urandom_range(0, 16000000)) - 8000000;
         cz = int'($urandom_range(0, 16000000)) - 8000000;
         made = 0;
         while (made < 12) begin
            roll = $urandom_range(0, 99);
            if (roll < 35) begin
               burst = $urandom_range(1, 6);
               repeat (burst) begin
                  send_req(KIND_LOAD, pick_slot(span), near_coord(cx), near_coord(cy),
                           near_coord(cz), cluster_radius(), GROUP_W'($urandom));
                  made++;
               end
            end else if (roll < 40) begin
               send_req(KIND_LOAD, pick_slot(0), rand_coord(), rand_coord(), rand_coord(),
                        RADIUS_W'($urandom), GROUP_W'($urandom));
               made++;
            end else begin
               scan_master(pick_slot(span));
               made++;
            end
         end
      end
      calm = 1'b0;

      req_valid <= 1'b0;
      for (int w = 0; w < 200000 && board.pending.size() > 0; w++)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (board.pending.size() > 0) begin
         $display("%0t missing result: expected m=%0d s=%0d v=%0b l=%0b, actual none (%0d left)",
                  $time, board.pending[0].master, board.pending[0].slave,
                  board.pending[0].pair_valid, board.pending[0].last, board.pending.size());
         board.mismatches++;
      end
      if (board.mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
